>>> rtl/ssdc_pkg.sv
// Shared types, frame mode codes and the CRC byte step for the stuffed stream deframer.
// Has no dependencies; every other file in rtl uses it.
package ssdc_pkg;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic [7:0] keystream_byte;
    logic       end_of_buffer;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_kind;
  } result_t;

  typedef struct packed {
    logic       pending;
    logic [8:0] frame_mode;
  } status_t;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [8:0] MODE_DATA = 9'h000;
  localparam logic [8:0] MODE_CRC0 = 9'h080;
  localparam logic [8:0] MODE_CRC1 = 9'h081;
  localparam logic [8:0] MODE_CRC2 = 9'h082;
  localparam logic [8:0] MODE_CRC3 = 9'h083;
  localparam logic [8:0] MODE_ESC  = 9'h100;

  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] ch);
    logic [31:0] c;
    c = crc ^ {ch, 24'h000000};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/ssdc_deframe.sv
// Input register, frame mode / CRC state and the per-byte deframing step.
// Depends on ssdc_pkg; pushes results into ssdc_skid.
module ssdc_deframe (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ssdc_pkg::item_t   item,
  input  logic              space,
  output logic              push,
  output ssdc_pkg::result_t push_data,
  output ssdc_pkg::status_t status
);

  logic              in_valid;
  ssdc_pkg::item_t   in_q;
  logic [8:0]        frame_mode;
  logic [31:0]       running_crc;
  logic [31:0]       received_crc;

  logic [8:0]        frame_mode_next;
  logic [31:0]       running_crc_next;
  logic [31:0]       received_crc_next;
  logic              fire;
  logic              emit;
  logic [7:0]        x;
  logic [31:0]       crc_x;
  logic [31:0]       crc_esc;
  logic [31:0]       rcv_full;

  assign fire       = in_valid && space;
  assign item_ready = !in_valid || space;
  assign push       = fire && emit;
  assign status     = '{pending: in_valid, frame_mode: frame_mode};

  assign x        = in_q.cipher_byte ^ in_q.keystream_byte;
  assign crc_x    = ssdc_pkg::crc_fold(running_crc, x);
  assign crc_esc  = ssdc_pkg::crc_fold(ssdc_pkg::crc_fold(running_crc, ssdc_pkg::BYTE_ZERO), x);
  assign rcv_full = received_crc | {24'h000000, x};

  always_comb begin
    frame_mode_next   = frame_mode;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    emit              = 1'b0;
    push_data         = '{out_byte: ssdc_pkg::BYTE_ZERO, out_kind: ssdc_pkg::KIND_DATA};
    priority if (frame_mode[8]) begin
      if (!x[7]) begin
        running_crc_next = crc_esc;
      end
      frame_mode_next = {1'b0, x};
      emit = (x == ssdc_pkg::BYTE_ZERO);
    end else if (frame_mode == ssdc_pkg::MODE_CRC0) begin
      received_crc_next = {x, 24'h000000};
      frame_mode_next   = ssdc_pkg::MODE_CRC1;
    end else if (frame_mode == ssdc_pkg::MODE_CRC1) begin
      received_crc_next = received_crc | {8'h00, x, 16'h0000};
      frame_mode_next   = ssdc_pkg::MODE_CRC2;
    end else if (frame_mode == ssdc_pkg::MODE_CRC2) begin
      received_crc_next = received_crc | {16'h0000, x, 8'h00};
      frame_mode_next   = ssdc_pkg::MODE_CRC3;
    end else if (frame_mode == ssdc_pkg::MODE_CRC3) begin
      received_crc_next = rcv_full;
      frame_mode_next   = ssdc_pkg::MODE_DATA;
      emit              = 1'b1;
      if (rcv_full != running_crc) begin
        push_data.out_kind = ssdc_pkg::KIND_ERROR;
      end else begin
        running_crc_next   = ssdc_pkg::CRC_INIT;
        push_data.out_byte = ssdc_pkg::BYTE_NEWLINE;
      end
    end else if (frame_mode != ssdc_pkg::MODE_DATA) begin
      running_crc_next = crc_x;
      frame_mode_next  = frame_mode - 9'd1;
    end else if (x == ssdc_pkg::BYTE_ZERO) begin
      frame_mode_next = ssdc_pkg::MODE_ESC;
    end else begin
      running_crc_next   = crc_x;
      emit               = 1'b1;
      push_data.out_byte = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode   <= ssdc_pkg::MODE_DATA;
      running_crc  <= ssdc_pkg::CRC_INIT;
      received_crc <= 32'h0000_0000;
    end else if (fire) begin
      frame_mode   <= frame_mode_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
    end
  end

endmodule

>>> rtl/ssdc_skid.sv
// Two-entry result buffer that decouples the deframer from the result receiver.
// Depends on ssdc_pkg for the result type.
module ssdc_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssdc_pkg::result_t push_data,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output ssdc_pkg::result_t result,
  output logic [1:0]        count
);

  ssdc_pkg::result_t buf0;
  ssdc_pkg::result_t buf1;
  logic [1:0]        count_next;
  logic              pop;

  assign space        = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = buf0;
  assign pop          = result_valid && result_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        buf0 <= buf1;
        if (push) begin
          buf1 <= push_data;
        end
      end else if (push) begin
        buf0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        buf0 <= push_data;
      end else begin
        buf1 <= push_data;
      end
    end
  end

endmodule

>>> rtl/stuffed_stream_deframer_crc_check.sv
// Top level of the stuffed stream deframer with CRC check.
// Depends on ssdc_pkg, ssdc_deframe and ssdc_skid.
//
// Usage:
//   item channel   (item_valid / item_ready / item): one cipher byte and its
//                  keystream byte per transfer; end_of_buffer is carried along
//                  and does not affect decoding.
//   result channel (result_valid / result_ready / result): zero or one result
//                  per item, in item order: a data byte, a newline after a
//                  matching CRC, or an error result after a mismatch.
//   Throughput: one item per cycle while the result buffer has space; the byte
//   step (escape decode plus up to two CRC byte folds) sits between the input
//   register and the result buffer. An item waits in the input register until
//   the result buffer has space; its result, if any, is then pushed into the
//   result buffer and shows on result_valid from there.
//   Reset: frame mode returns to normal data, the running CRC to all ones,
//   the received CRC to zero, and the input and result buffers empty.
//   Receiver stall: the two-entry result buffer absorbs results; once it is
//   full the input register holds its byte and item_ready drops.
module stuffed_stream_deframer_crc_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ssdc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output ssdc_pkg::result_t result
);

  logic              space;
  logic              push;
  ssdc_pkg::result_t push_data;
  ssdc_pkg::status_t status;
  logic [1:0]        count;

  ssdc_deframe u_deframe (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .space      (space),
    .push       (push),
    .push_data  (push_data),
    .status     (status)
  );

  ssdc_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .count        (count)
  );

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    !(status.frame_mode[8] && (status.frame_mode[7:0] != 8'h00)))
    else $error("frame mode in unused escape range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer overfilled");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push && (count == 2'd0) |=> result_valid)
    else $error("pushed result not presented");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    status.pending && !space |=> status.pending)
    else $error("stalled input byte dropped");

endmodule

>>> test/ssdc_stream_checker.sv
// Checker for the stuffed stream deframer: watches both channels, predicts each result
// from the accepted bytes and compares. Depends on ssdc_pkg for payload types and codes.
module ssdc_stream_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  ssdc_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  ssdc_pkg::result_t result,
  output int                fail_count,
  output int                pending,
  output logic [8:0]        frame_mode,
  output logic [31:0]       line_crc,
  output int                n_data,
  output int                n_good,
  output int                n_bad
);
  import ssdc_pkg::*;

  logic [31:0] rcv_crc;
  result_t     expected_results[$];
  result_t     want;

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      r = {r[30:0], 1'b0} ^ ((r[31] ^ b[k]) ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  task automatic expect_out(input logic [7:0] b, input logic kind);
    result_t r;
    r.out_byte = b;
    r.out_kind = kind;
    expected_results.push_back(r);
  endtask

  task automatic decode_byte(input item_t it);
    logic [7:0] x;
    x = it.cipher_byte ^ it.keystream_byte;
    if (frame_mode[8]) begin
      if (!x[7]) begin
        line_crc = crc_step(crc_step(line_crc, BYTE_ZERO), x);
      end
      frame_mode = {1'b0, x};
      if (x == BYTE_ZERO) begin
        expect_out(BYTE_ZERO, KIND_DATA);
        n_data++;
      end
    end else if (frame_mode == MODE_CRC0) begin
      rcv_crc = {x, 24'h0};
      frame_mode = MODE_CRC1;
    end else if (frame_mode == MODE_CRC1) begin
      rcv_crc = rcv_crc | {8'h0, x, 16'h0};
      frame_mode = MODE_CRC2;
    end else if (frame_mode == MODE_CRC2) begin
      rcv_crc = rcv_crc | {16'h0, x, 8'h0};
      frame_mode = MODE_CRC3;
    end else if (frame_mode == MODE_CRC3) begin
      rcv_crc = rcv_crc | {24'h0, x};
      frame_mode = MODE_DATA;
      if (rcv_crc != line_crc) begin
        expect_out(BYTE_ZERO, KIND_ERROR);
        n_bad++;
      end else begin
        line_crc = CRC_INIT;
        expect_out(BYTE_NEWLINE, KIND_DATA);
        n_good++;
      end
    end else if (frame_mode != MODE_DATA) begin
      line_crc = crc_step(line_crc, x);
      frame_mode = frame_mode - 9'd1;
    end else if (x == BYTE_ZERO) begin
      frame_mode = MODE_ESC;
    end else begin
      line_crc = crc_step(line_crc, x);
      expect_out(x, KIND_DATA);
      n_data++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_mode = MODE_DATA;
      line_crc = CRC_INIT;
      rcv_crc = 32'h0;
      expected_results.delete();
      fail_count = 0;
      n_data = 0;
      n_good = 0;
      n_bad = 0;
    end else begin
      if (item_valid && item_ready) begin
        decode_byte(item);
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transfer: out_byte %02h out_kind %0b",
                 result.out_byte, result.out_kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
            fail_count++;
          end
          if (result.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0b, got %0b", want.out_kind, result.out_kind);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> test/tb_stuffed_stream_deframer_crc_check.sv
// Testbench top for stuffed_stream_deframer_crc_check: builds framed, keystream-masked
// byte lines with good and bad CRCs plus odd escapes and noise; ssdc_stream_checker judges.
// Depends on ssdc_pkg, the block under test and ssdc_stream_checker.
module tb_stuffed_stream_deframer_crc_check;
  import ssdc_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;

  typedef enum int {TOK_DATA, TOK_ZERO, TOK_FILL} token_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_style_e;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  int          fail_count;
  int          pending;
  logic [8:0]  frame_mode;
  logic [31:0] line_crc;
  int          n_data;
  int          n_good;
  int          n_bad;

  int sent;
  int cycles;
  int burst_left;
  bit steady;
  bit hold_req;
  bit hold_taken;
  bit holding;

  stuffed_stream_deframer_crc_check u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  ssdc_stream_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .frame_mode   (frame_mode),
    .line_crc     (line_crc),
    .n_data       (n_data),
    .n_good       (n_good),
    .n_bad        (n_bad)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("stuffed_stream_deframer_crc_check: mismatch");
    $finish;
  end

  // receiver: stall patterns in windows, plus one long hold-off on request
  initial begin
    rx_style_e style;
    int        window;
    int        tick;
    int        hold_left;
    result_ready = 1'b0;
    holding = 1'b0;
    hold_taken = 1'b0;
    window = 0;
    tick = 0;
    hold_left = 0;
    style = RX_OPEN;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        holding = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (holding) begin
        result_ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) begin
          holding = 1'b0;
        end
      end else begin
        if (window == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          window = $urandom_range(20, 150);
        end
        window--;
        tick++;
        case (style)
          RX_OPEN:   result_ready <= 1'b1;
          RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
          RX_THIRD:  result_ready <= (tick % 3 == 0);
          default:   result_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // crc_byte takes the next trailer byte from the predicted line CRC; corrupt flips one bit
  task automatic offer_byte(input logic [7:0] plain, input bit crc_byte, input bit corrupt);
    logic [7:0] ks;
    logic [7:0] x;
    int         gap;
    @(negedge clk);
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    x = plain;
    if (crc_byte) begin
      case (frame_mode)
        MODE_CRC0: x = line_crc[31:24];
        MODE_CRC1: x = line_crc[23:16];
        MODE_CRC2: x = line_crc[15:8];
        MODE_CRC3: x = line_crc[7:0];
        default:   x = 8'($urandom_range(0, 255));
      endcase
      if (corrupt) begin
        x = x ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    ks = 8'($urandom_range(0, 255));
    item <= {x ^ ks, ks, ($urandom_range(0, 7) == 0)};
    item_valid <= 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end
    do @(posedge clk); while (!item_ready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic emit_trailer(input bit bad);
    int bad_pos;
    bad_pos = $urandom_range(0, 3);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(MODE_CRC0[7:0], 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) begin
      offer_byte(BYTE_ZERO, 1'b1, bad && k == bad_pos);
    end
  endtask

  task automatic emit_line();
    int     n_tok;
    int     n;
    int     r;
    token_e tk;
    n_tok = $urandom_range(0, 12);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(0, 9);
      tk = (r < 6) ? TOK_DATA : (r < 8) ? TOK_ZERO : TOK_FILL;
      case (tk)
        TOK_DATA: offer_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
        TOK_ZERO: begin
          offer_byte(BYTE_ZERO, 1'b0, 1'b0);
          offer_byte(BYTE_ZERO, 1'b0, 1'b0);
        end
        default: begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
          offer_byte(BYTE_ZERO, 1'b0, 1'b0);
          offer_byte(8'(n), 1'b0, 1'b0);
          repeat (n) offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
      endcase
    end
    emit_trailer($urandom_range(0, 6) == 0);
  endtask

  // escape followed by 0x81..0xFF: partial trailer entry or filler countdown into the last byte
  task automatic emit_odd_escape();
    int r;
    int v;
    int n;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      v = $urandom_range(MODE_CRC1[7:0], MODE_CRC3[7:0]);
    end else if (r < 9) begin
      v = $urandom_range(8'h84, 8'h8A);
    end else begin
      v = $urandom_range(8'hC0, 8'hFF);
    end
    n = (v > MODE_CRC3[7:0]) ? v - MODE_CRC3[7:0] + 1 : MODE_CRC3[7:0] - v + 1;
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(8'(v), 1'b0, 1'b0);
    repeat (n) offer_byte(BYTE_ZERO, 1'b1, $urandom_range(0, 3) == 0);
  endtask

  task automatic run_directed();
    offer_byte(8'h01, 1'b0, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b0);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(8'h01, 1'b0, 1'b0);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    emit_trailer(1'b0);
    emit_trailer(1'b1);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(MODE_CRC3[7:0], 1'b0, 1'b0);
    offer_byte(BYTE_ZERO, 1'b1, 1'b0);
    offer_byte(BYTE_ZERO, 1'b0, 1'b0);
    offer_byte(8'h84, 1'b0, 1'b0);
    offer_byte(8'h5A, 1'b0, 1'b0);
    offer_byte(BYTE_ZERO, 1'b1, 1'b0);
  endtask

  initial begin
    int r;
    int target;
    bit hold_done;
    bit drained;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    sent = 0;
    burst_left = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    drain();

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      if (!hold_done && sent >= target - 1300) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drained && sent >= target - 700) begin
        drain();
        drained = 1'b1;
      end
      steady = (hold_req && !hold_taken) || holding || ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 19);
      if (r < 15) begin
        emit_line();
      end else if (r < 18) begin
        emit_odd_escape();
      end else begin
        repeat ($urandom_range(1, 5)) offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
    end

    drain();
    repeat (20) @(negedge clk);

    $display("run: %0d byte transfers in %0d cycles, incl. hold-off and drain pauses",
             sent, cycles);
    $display("out: %0d data bytes, %0d lines with good CRC, %0d CRC errors",
             n_data, n_good, n_bad);
    if (fail_count == 0) begin
      $display("stuffed_stream_deframer_crc_check: match");
    end else begin
      $display("stuffed_stream_deframer_crc_check: mismatch");
    end
    $finish;
  end

endmodule
